>>> src/tmt32_pkg.sv
// Shared types, constants and functions of the TinyMT32 generator.
`timescale 1ns / 1ps

package tmt32_pkg;

	// Generator parameter set.
	localparam logic [31:0] MAT1      = 32'h8f7011ee;
	localparam logic [31:0] MAT2      = 32'hfc78ff1f;
	localparam logic [31:0] TMAT      = 32'h3793fdff;
	localparam logic [31:0] INIT_MULT = 32'h6c078965;
	localparam logic [31:0] LOW31     = 32'h7FFFFFFF;

	// Replacement words for an all-zero expanded state ("TINY").
	localparam logic [31:0] TINY_W0 = 32'h00000054;
	localparam logic [31:0] TINY_W1 = 32'h00000049;
	localparam logic [31:0] TINY_W2 = 32'h0000004E;
	localparam logic [31:0] TINY_W3 = 32'h00000059;

	// Step counts and jump table sizes.
	localparam int unsigned JUMP_TABLE_ENTRIES = 25;
	localparam int unsigned PLAIN_BITS         = 7;
	localparam int unsigned REST_BITS          = 32 - PLAIN_BITS;
	localparam logic [7:0]  WARMUP_STEPS       = 8'd8;
	localparam logic [2:0]  LAST_ROUND         = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] CFG_INIT_MODE = 3'd0;
	localparam logic [2:0] CFG_SEED0     = 3'd1;
	localparam logic [2:0] CFG_SEED1     = 3'd2;
	localparam logic [2:0] CFG_SEED2     = 3'd3;
	localparam logic [2:0] CFG_SEED3     = 3'd4;

	// Generator state, word 0 at index 0.
	typedef logic [3:0][31:0] gen_state_t;

	// Operation codes carried in the input item.
	typedef enum logic [1:0] {
		OP_DRAW    = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_JUMP    = 2'd2,
		OP_REINIT  = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_EXPAND,
		ST_FIX,
		ST_STEP,
		ST_JSCAN,
		ST_JWALK,
		ST_JLOAD
	} ctrl_state_t;

	// Datapath actions.
	typedef enum logic [3:0] {
		DP_HOLD,
		DP_DRAW,
		DP_STEP,
		DP_LOAD_DIRECT,
		DP_LOAD_EXPAND,
		DP_EXPAND_ROUND,
		DP_FIX_ZERO,
		DP_JUMP_START,
		DP_JUMP_WALK,
		DP_JUMP_LOAD
	} dp_op_t;

	// Command from controller to datapath.
	typedef struct packed {
		dp_op_t     op;
		logic [2:0] round;
		logic [4:0] poly_idx;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic init_mode;
	} dp_status_t;

	// One step of the state recurrence.
	function automatic gen_state_t step_state(gen_state_t s);
		logic [31:0] x;
		logic [31:0] y;
		gen_state_t  r;
		begin
			x = (s[0] & LOW31) ^ s[1] ^ s[2];
			x = x ^ (x << 1);
			y = s[3];
			y = y ^ (y >> 1) ^ x;
			r[0] = s[1];
			r[1] = s[2] ^ (y[0] ? MAT1 : 32'h0);
			r[2] = x ^ (y << 10) ^ (y[0] ? MAT2 : 32'h0);
			r[3] = y;
			return r;
		end
	endfunction

	// Output tempering of a state.
	function automatic logic [31:0] temper(gen_state_t s);
		logic [31:0] t0;
		logic [31:0] t1;
		begin
			t1 = s[0] + (s[2] >> 8);
			t0 = s[3] ^ t1;
			if (t1[0]) begin
				t0 = t0 ^ TMAT;
			end
			return t0;
		end
	endfunction

	// Jump polynomials. Bit j is the coefficient applied at walk step j:
	// the low 64 bits come from the second word of an entry, the high 64
	// bits from the first.
	function automatic logic [127:0] jump_poly(logic [4:0] idx);
		logic [127:0] p;
		begin
			case (idx)
				5'd0:  p = {64'hb0a48045db1bfe95, 64'h1b98a18f31f57486};
				5'd1:  p = {64'he29d1503ee564039, 64'h342d0c6dc777e228};
				5'd2:  p = {64'hfd7a37b1acaa7823, 64'h9951a06456708b7e};
				5'd3:  p = {64'h5ab81fcd13ccd9fa, 64'hce6673b3d158340e};
				5'd4:  p = {64'he7d0c5907aee0eea, 64'h090d98e45a895878};
				5'd5:  p = {64'h2e1bd6473d093826, 64'h61def4964ec4ab34};
				5'd6:  p = {64'h33ae14e5d2005a71, 64'h334a0fe77ab182de};
				5'd7:  p = {64'hd654b5930b12fe3e, 64'h3794cc23a5de8a5e};
				5'd8:  p = {64'h0586e1d6b2670a75, 64'h86bf0979d37c9a1e};
				5'd9:  p = {64'h8d859b2a345b1a3f, 64'he2d08ec75db83196};
				5'd10: p = {64'h9d2132eac57edc3a, 64'hd8731c41bcf9f318};
				5'd11: p = {64'ha5c8c0d51e112335, 64'h2ebb41367c1e3386};
				5'd12: p = {64'h7c5c99ea483c815a, 64'h9f1173b680f6752e};
				5'd13: p = {64'h658cd2f421d18c04, 64'h41fbd20233bcb628};
				5'd14: p = {64'h694898799783db46, 64'hc8fc1f0f485cc220};
				5'd15: p = {64'h4cf6c5ecc4826e0b, 64'h8e695f0109724eb6};
				5'd16: p = {64'hf20cef18f4cd9a96, 64'h7478b18cfd3ccb36};
				5'd17: p = {64'h9f0de9fe452bc110, 64'h7feb70c475efda16};
				5'd18: p = {64'habf913e20fcbe635, 64'h1ad541a07a6c610a};
				5'd19: p = {64'h20999170716ca869, 64'h203777ca7d356342};
				5'd20: p = {64'h5dcb2d78b3e9ca0f, 64'h7222f0529a9dd99c};
				5'd21: p = {64'h197365ac9569a8b4, 64'h6dd7a644730f081a};
				5'd22: p = {64'hf2156d44b37e61be, 64'h80bfd2b6153ed5cc};
				5'd23: p = {64'hac7a0ab2f43b15a9, 64'h227df3de640734f4};
				5'd24: p = {64'h40afea91e9ad4b2c, 64'h58440d15ded1d336};
				default: p = 128'h0;
			endcase
			return p;
		end
	endfunction

endpackage

>>> src/tmt32_ctrl.sv
// Controller state machine of the TinyMT32 generator.
`timescale 1ns / 1ps

module tmt32_ctrl
	import tmt32_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] s_op,
	input  logic [31:0] s_count,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic       cfg_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	ctrl_state_t          state_q, state_d;
	logic [7:0]           cnt_q, cnt_d;
	logic [REST_BITS-1:0] rest_q, rest_d;
	logic [4:0]           idx_q, idx_d;
	logic [6:0]           walk_q, walk_d;
	logic [2:0]           round_q, round_d;
	logic                 out_valid_q, out_valid_d;
	logic                 boot_q;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT;
			cnt_q       <= '0;
			rest_q      <= '0;
			idx_q       <= '0;
			walk_q      <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
			boot_q      <= 1'b1;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rest_q      <= rest_d;
			idx_q       <= idx_d;
			walk_q      <= walk_d;
			round_q     <= round_d;
			out_valid_q <= out_valid_d;
			if (state_q == ST_IDLE) begin
				boot_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		rest_d       = rest_q;
		idx_d        = idx_q;
		walk_d       = walk_q;
		round_d      = round_q;
		out_valid_d  = out_valid_q && !m_tready;
		s_tready     = 1'b0;
		cmd.op       = DP_HOLD;
		cmd.round    = round_q;
		cmd.poly_idx = idx_q;
		case (state_q)
			ST_BOOT: begin
				if (status.init_mode) begin
					cmd.op  = DP_LOAD_DIRECT;
					state_d = ST_IDLE;
				end else begin
					cmd.op  = DP_LOAD_EXPAND;
					round_d = 3'd1;
					state_d = ST_EXPAND;
				end
			end
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				if (s_tvalid && s_tready) begin
					case (op_t'(s_op))
						OP_DRAW: begin
							cmd.op      = DP_DRAW;
							out_valid_d = 1'b1;
						end
						OP_ADVANCE: begin
							// Short advances step plainly; long ones go through
							// the jump polynomials.
							if (s_count[31:8] == 24'h0) begin
								cnt_d  = s_count[7:0];
								rest_d = '0;
							end else begin
								cnt_d  = {1'b0, s_count[PLAIN_BITS-1:0]};
								rest_d = s_count[31:PLAIN_BITS];
							end
							idx_d   = '0;
							state_d = ST_STEP;
						end
						OP_JUMP: begin
							cnt_d   = {1'b0, s_count[PLAIN_BITS-1:0]};
							rest_d  = s_count[31:PLAIN_BITS];
							idx_d   = '0;
							state_d = ST_STEP;
						end
						OP_REINIT: begin
							if (status.init_mode) begin
								cmd.op = DP_LOAD_DIRECT;
							end else begin
								cmd.op  = DP_LOAD_EXPAND;
								round_d = 3'd1;
								state_d = ST_EXPAND;
							end
						end
						default: begin
							cmd.op = DP_HOLD;
						end
					endcase
				end
			end
			ST_EXPAND: begin
				cmd.op  = DP_EXPAND_ROUND;
				round_d = round_q + 3'd1;
				if (round_q == LAST_ROUND) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.op  = DP_FIX_ZERO;
				cnt_d   = WARMUP_STEPS;
				rest_d  = '0;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (cnt_q == 8'd0) begin
					state_d = ST_JSCAN;
				end else begin
					cmd.op = DP_STEP;
					cnt_d  = cnt_q - 8'd1;
				end
			end
			ST_JSCAN: begin
				// Look at the next count bit above the plain steps.
				if (rest_q == '0) begin
					state_d = ST_IDLE;
				end else if (rest_q[0] && (idx_q < 5'(JUMP_TABLE_ENTRIES))) begin
					cmd.op  = DP_JUMP_START;
					walk_d  = '0;
					state_d = ST_JWALK;
				end else begin
					rest_d = rest_q >> 1;
					idx_d  = idx_q + 5'd1;
				end
			end
			ST_JWALK: begin
				cmd.op = DP_JUMP_WALK;
				walk_d = walk_q + 7'd1;
				if (&walk_q) begin
					state_d = ST_JLOAD;
				end
			end
			ST_JLOAD: begin
				cmd.op  = DP_JUMP_LOAD;
				rest_d  = rest_q >> 1;
				idx_d   = idx_q + 5'd1;
				state_d = ST_JSCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid  = out_valid_q;
	assign cfg_ready = !boot_q;

endmodule

>>> src/tmt32_datapath.sv
// Datapath of the TinyMT32 generator: state, jump accumulator, registers, output.
`timescale 1ns / 1ps

module tmt32_datapath
	import tmt32_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic [47:0] out_data
);

	logic              mode_q;
	logic [3:0][31:0]  seed_q;
	gen_state_t        gen_q, gen_d;
	gen_state_t        sum_q, sum_d;
	logic [127:0]      poly_q, poly_d;
	logic [31:0]       out_q, out_d;
	gen_state_t        stepped;
	logic [31:0]       prev_w;
	logic [31:0]       mix_w;
	logic [31:0]       prod_w;
	logic [1:0]        wr_sel;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			seed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INIT_MODE: mode_q    <= cfg_data[0];
				CFG_SEED0:     seed_q[0] <= cfg_data;
				CFG_SEED1:     seed_q[1] <= cfg_data;
				CFG_SEED2:     seed_q[2] <= cfg_data;
				CFG_SEED3:     seed_q[3] <= cfg_data;
				default:       mode_q    <= mode_q;
			endcase
		end
	end

	// One expansion round: multiply the previous word and fold it into the next.
	always_comb begin
		wr_sel = cmd.round[1:0];
		prev_w = gen_q[wr_sel - 2'd1];
		mix_w  = prev_w ^ (prev_w >> 30);
		prod_w = INIT_MULT * mix_w;
	end

	// Next values of the state, accumulator, polynomial and output.
	always_comb begin
		stepped = step_state(gen_q);
		gen_d   = gen_q;
		sum_d   = sum_q;
		poly_d  = poly_q;
		out_d   = out_q;
		case (cmd.op)
			DP_DRAW: begin
				gen_d = stepped;
				out_d = temper(stepped);
			end
			DP_STEP: begin
				gen_d = stepped;
			end
			DP_LOAD_DIRECT: begin
				gen_d = seed_q;
			end
			DP_LOAD_EXPAND: begin
				gen_d[0] = seed_q[0];
				gen_d[1] = MAT1;
				gen_d[2] = MAT2;
				gen_d[3] = TMAT;
			end
			DP_EXPAND_ROUND: begin
				gen_d[wr_sel] = gen_q[wr_sel] ^ (prod_w + {29'h0, cmd.round});
			end
			DP_FIX_ZERO: begin
				if (((gen_q[0] & LOW31) == 32'h0) && (gen_q[1] == 32'h0) &&
				    (gen_q[2] == 32'h0) && (gen_q[3] == 32'h0)) begin
					gen_d[0] = TINY_W0;
					gen_d[1] = TINY_W1;
					gen_d[2] = TINY_W2;
					gen_d[3] = TINY_W3;
				end
			end
			DP_JUMP_START: begin
				sum_d  = '0;
				poly_d = jump_poly(cmd.poly_idx);
			end
			DP_JUMP_WALK: begin
				if (poly_q[0]) begin
					sum_d = sum_q ^ gen_q;
				end
				gen_d  = stepped;
				poly_d = poly_q >> 1;
			end
			DP_JUMP_LOAD: begin
				gen_d = sum_q;
			end
			default: begin
				gen_d = gen_q;
			end
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		gen_q  <= gen_d;
		sum_q  <= sum_d;
		poly_q <= poly_d;
		out_q  <= out_d;
	end

	assign status.init_mode = mode_q;
	assign out_data         = {out_q[31:16], out_q};

endmodule

>>> src/tinymt32_generator.sv
// Top level of the TinyMT32 generator: controller and datapath.
//
// Input items arrive on the s_ stream: s_tuser holds the operation (draw,
// advance, jump, reinitialize) and s_tdata the step count. Only a draw gives
// a result item on the m_ stream: the tempered word and its upper half.
// Configuration registers (mode and four seed words) are written on the cfg_
// channel by index, by the user only while the block is idle (unchecked).
//
// A draw's result is in the output register the cycle after acceptance,
// and draws are accepted every cycle while the receiver takes results.
// An advance by n below 256 steps the state plainly n times. Jumps, and
// advances of 256 or more, step plainly (count mod 128) times and then
// scan each count bit above bit 6 up to the highest set one; each set bit
// walks 128 successive states through the single state-step unit and
// then loads the sum.
// A reinitialize in direct mode loads the seed words; in expansion mode it
// runs seven multiply rounds, a zero check and eight warm-up steps.
//
// After reset the block expands seed 0 with s_tready low; cfg_ready
// rises in the cycle after s_tready first rises. While a result waits for
// m_tready, no new item is taken.
`timescale 1ns / 1ps

module tinymt32_generator
	import tmt32_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] step_count
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] random_word, [47:32] random_half
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing of operations.
	tmt32_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_op      (s_tuser),
		.s_count   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// State, arithmetic and configuration storage.
	tmt32_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata)
	);

endmodule

>>> src/tmt32_checker.sv
// Port-level assertions for the TinyMT32 generator and their binding.
`timescale 1ns / 1ps

module tmt32_checker
	import tmt32_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	// The half field is the upper half of the word.
	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:32] == m_tdata[31:16]))
		else $error("random_half does not match random_word");

	// No item is taken while a result waits unclaimed.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input accepted while output is stalled");

	// Only a draw produces a result item.
	a_draw_only: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != OP_DRAW) |=> !$rose(m_tvalid))
		else $error("result item from a non-draw operation");

endmodule

bind tinymt32_generator tmt32_checker u_tmt32_checker (.*);
